>>> hdl/fnvh64_pkg.sv
// Shared types and constants for the word-wise 64-bit FNV-1a hash block.
`default_nettype none

package fnvh64_pkg;

   // Width of one data word and of one serial digit.
   localparam int WORD_W  = 64;
   localparam int DIGIT_W = 8;

   // Bytes in a full data word, sized like the byte count field.
   localparam logic [3:0] WORD_BYTES = 4'd8;

   // The 64-bit FNV prime is 2^40 + 0x1b3; the multiply unit uses the two parts.
   localparam int         PRIME_SHIFT = 40;
   localparam logic [8:0] PRIME_LOW   = 9'h1b3;

   // FNV offset basis, the reset value of the seed and of the running hash.
   localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;

   // Register file: byte address bits and the index of the seed register.
   localparam int   CSR_ADDR_W     = 4;
   localparam logic CSR_SEED_INDEX = 1'b0;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MIX,
      ST_FOLD
   } state_type;

   // Control group from the sequencer to the multiply unit.
   typedef struct packed {
      logic load;
      logic step;
      logic first;
   } mac_ctrl_type;

   // Input beat.
   typedef struct packed {
      logic [63:0] data_word;
      logic [3:0]  byte_count;
      logic        last_of_buffer;
      logic        restart;
   } req_payload_type;

   // Result beat.
   typedef struct packed {
      logic [63:0] hash_value;
   } rsp_payload_type;

endpackage

`default_nettype wire

>>> hdl/fnvh64_if.sv
// Valid/ready channel interfaces for the input and result beats.
`default_nettype none

interface fnvh64_req_if;
   logic                        valid;
   logic                        ready;
   fnvh64_pkg::req_payload_type beat;

   modport source (output valid, output beat, input ready);
   modport sink (input valid, input beat, output ready);
endinterface

interface fnvh64_rsp_if;
   logic                        valid;
   logic                        ready;
   fnvh64_pkg::rsp_payload_type beat;

   modport source (output valid, output beat, input ready);
   modport sink (input valid, input beat, output ready);
endinterface

`default_nettype wire

>>> hdl/fnvh64_csr.sv
// APB-style register port holding the seed register.
`default_nettype none

module fnvh64_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [fnvh64_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [63:0]                       csr_pwdata,
   output logic [63:0]                            csr_prdata,
   output logic                                   csr_pready,
   output logic [63:0]                            seed
);

   logic [63:0] seed_ff;
   logic [63:0] seed_in;
   logic        seed_sel;
   logic        wr_fire;

   // Registers sit on 8-byte boundaries, so bit 3 selects the register.
   assign seed_sel = (csr_paddr[3] == fnvh64_pkg::CSR_SEED_INDEX);
   assign wr_fire  = csr_psel && csr_penable && csr_pwrite;

   // Seed update on the access phase of a write.
   always_comb begin
      seed_in = seed_ff;
      if (wr_fire && seed_sel) begin
         seed_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= fnvh64_pkg::FNV_BASIS;
      end else begin
         seed_ff <= seed_in;
      end
   end

   // Read data; addresses past the register list read as zero.
   assign csr_prdata = seed_sel ? seed_ff : 64'd0;
   assign csr_pready = 1'b1;
   assign seed       = seed_ff;

endmodule

`default_nettype wire

>>> hdl/fnvh64_mac.sv
// Digit-serial XOR-and-multiply unit holding the running hash.
`default_nettype none

module fnvh64_mac (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire fnvh64_pkg::mac_ctrl_type ctrl,
   input  wire logic [63:0]              load_value,
   input  wire logic [7:0]               operand_digit,
   output logic [63:0]                   hash_value
);

   // While stepping, the hash shifts out one byte per cycle at the bottom while
   // product bytes shift in at the top; after eight steps it holds the product.
   logic [63:0] hash_ff;
   logic [63:0] hash_in;
   logic [40:0] carry_ff;
   logic [40:0] carry_in;
   logic [7:0]  digit;
   logic [16:0] low_prod;
   logic [47:0] partial;
   logic [48:0] sum;

   // One byte of (hash ^ operand) times the prime, plus the carried sum.
   always_comb begin
      digit    = hash_ff[7:0] ^ operand_digit;
      low_prod = 17'(digit) * 17'(fnvh64_pkg::PRIME_LOW);
      partial  = {digit, 23'd0, low_prod};
      sum      = 49'(partial) + (ctrl.first ? 49'd0 : 49'(carry_ff));
   end

   // Next hash and carry.
   always_comb begin
      hash_in  = hash_ff;
      carry_in = carry_ff;
      if (ctrl.load) begin
         hash_in = load_value;
      end else if (ctrl.step) begin
         hash_in  = {sum[7:0], hash_ff[63:8]};
         carry_in = sum[48:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= fnvh64_pkg::FNV_BASIS;
      end else begin
         hash_ff <= hash_in;
      end
   end

   // The carry is cleared through the first flag, so it needs no reset.
   always_ff @(posedge clock) begin
      carry_ff <= carry_in;
   end

   assign hash_value = hash_ff;

endmodule

`default_nettype wire

>>> hdl/word_fnv1a_hash64.sv
// Top level of the word-wise 64-bit FNV-1a hash: sequencer, length counter and result register.
`default_nettype none

// Hashes a chain of buffers, eight little-endian bytes per input beat. The
// prime multiply is done one byte of the hash per cycle, so one fold steps
// through all eight bytes of the hash. A non-last beat and a full last beat
// take one fold each, a short last beat of n bytes takes one fold per byte,
// and an empty one none; a last beat then passes through the final state. The
// result register holds a finished hash while the next beat is taken; a new
// result waits in the final state only if the previous one is still pending.
// The seed register sits at byte address 0 and is written through the APB port;
// write it only while the block is idle; the block itself does not enforce it.
module word_fnv1a_hash64 (
   input  wire logic                              clock,
   input  wire logic                              reset,
   fnvh64_req_if.sink                             req_chan,
   fnvh64_rsp_if.source                           rsp_chan,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [fnvh64_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [63:0]                       csr_pwdata,
   output logic [63:0]                            csr_prdata,
   output logic                                   csr_pready
);

   fnvh64_pkg::state_type    state_ff;
   fnvh64_pkg::state_type    state_in;
   fnvh64_pkg::mac_ctrl_type mac_ctrl;

   logic [63:0] seed;
   logic [63:0] hash;
   logic [63:0] mac_load_value;
   logic [7:0]  operand_digit;

   logic [63:0] word_ff;
   logic [63:0] word_in;
   logic        full_ff;
   logic        full_in;
   logic        last_ff;
   logic        last_in;
   logic [2:0]  rem_ff;
   logic [2:0]  rem_in;
   logic [2:0]  dig_ff;
   logic [2:0]  dig_in;
   logic [63:0] len_ff;
   logic [63:0] len_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [63:0] rsp_hash_ff;
   logic [63:0] rsp_hash_in;

   logic        accept;
   logic        fold_fire;
   logic        req_ready;
   logic [3:0]  cnt_sat;
   logic        item_full;
   logic [3:0]  len_add;
   logic [2:0]  item_rem;
   logic        mix_end;

   fnvh64_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .seed        (seed)
   );

   fnvh64_mac u_mac (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (mac_ctrl),
      .load_value    (mac_load_value),
      .operand_digit (operand_digit),
      .hash_value    (hash)
   );

   // Decode of the incoming beat: counts above eight saturate, and only a
   // short last beat is folded byte by byte.
   always_comb begin
      cnt_sat   = (req_chan.beat.byte_count > fnvh64_pkg::WORD_BYTES) ?
                  fnvh64_pkg::WORD_BYTES : req_chan.beat.byte_count;
      item_full = !req_chan.beat.last_of_buffer || (cnt_sat == fnvh64_pkg::WORD_BYTES);
      len_add   = req_chan.beat.last_of_buffer ? cnt_sat : fnvh64_pkg::WORD_BYTES;
      item_rem  = item_full ? 3'd1 : cnt_sat[2:0];
   end

   assign accept  = req_chan.valid && req_ready;
   assign mix_end = (state_ff == fnvh64_pkg::ST_MIX) && (dig_ff == 3'd7);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fnvh64_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (item_rem == 3'd0) ? fnvh64_pkg::ST_FOLD : fnvh64_pkg::ST_MIX;
            end
         end
         fnvh64_pkg::ST_MIX: begin
            if (mix_end && (rem_ff == 3'd1)) begin
               state_in = last_ff ? fnvh64_pkg::ST_FOLD : fnvh64_pkg::ST_IDLE;
            end
         end
         fnvh64_pkg::ST_FOLD: begin
            if (fold_fire) begin
               state_in = fnvh64_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fnvh64_pkg::ST_IDLE;
         end
      endcase
   end

   // State outputs: input ready, multiply unit control and the fold strobe.
   // The input is held off while reset is asserted.
   always_comb begin
      req_ready      = 1'b0;
      fold_fire      = 1'b0;
      mac_ctrl       = '0;
      mac_load_value = seed;
      case (state_ff)
         fnvh64_pkg::ST_IDLE: begin
            req_ready     = !reset;
            mac_ctrl.load = req_chan.valid && req_chan.beat.restart;
         end
         fnvh64_pkg::ST_MIX: begin
            mac_ctrl.step  = 1'b1;
            mac_ctrl.first = (dig_ff == 3'd0);
         end
         fnvh64_pkg::ST_FOLD: begin
            fold_fire      = !rsp_valid_ff || rsp_chan.ready;
            mac_ctrl.load  = fold_fire;
            mac_load_value = hash ^ len_ff;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // A full word feeds a new byte every cycle; a short beat feeds one byte
   // into the lowest digit of each fold and zero elsewhere.
   assign operand_digit = (full_ff || (dig_ff == 3'd0)) ? word_ff[7:0] : 8'd0;

   // Beat capture, digit and fold counters, length and result register.
   always_comb begin
      word_in      = word_ff;
      full_in      = full_ff;
      last_in      = last_ff;
      rem_in       = rem_ff;
      dig_in       = dig_ff;
      len_in       = len_ff;
      rsp_hash_in  = rsp_hash_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (accept) begin
         word_in = req_chan.beat.data_word;
         full_in = item_full;
         last_in = req_chan.beat.last_of_buffer;
         rem_in  = item_rem;
         dig_in  = 3'd0;
         len_in  = (req_chan.beat.restart ? 64'd0 : len_ff) + 64'(len_add);
      end
      if (state_ff == fnvh64_pkg::ST_MIX) begin
         dig_in = dig_ff + 3'd1;
         if (full_ff || (dig_ff == 3'd7)) begin
            word_in = {8'd0, word_ff[63:8]};
         end
         if (mix_end) begin
            rem_in = rem_ff - 3'd1;
         end
      end
      if (fold_fire) begin
         rsp_hash_in  = hash ^ len_ff;
         rsp_valid_in = 1'b1;
         len_in       = 64'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fnvh64_pkg::ST_IDLE;
         dig_ff       <= 3'd0;
         rem_ff       <= 3'd0;
         len_ff       <= 64'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dig_ff       <= dig_in;
         rem_ff       <= rem_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      full_ff     <= full_in;
      last_ff     <= last_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   assign req_chan.ready            = req_ready;
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.beat.hash_value  = rsp_hash_ff;

   // The digit counter only moves while a fold is running.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != fnvh64_pkg::ST_MIX) |-> (dig_ff == 3'd0))
      else $error("digit counter not at zero outside a fold");

   // A fold never runs with no folds left to do.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == fnvh64_pkg::ST_MIX) |-> (rem_ff != 3'd0))
      else $error("fold running with zero remaining");

   // Emitting a result ends the buffer and clears its length.
   assert property (@(posedge clock) disable iff (reset)
      fold_fire |=> (len_ff == 64'd0))
      else $error("buffer length not cleared after a result");

   // A non-last beat takes exactly one fold and then returns to idle.
   assert property (@(posedge clock) disable iff (reset)
      (accept && !req_chan.beat.last_of_buffer) |-> ##9 (state_ff == fnvh64_pkg::ST_IDLE))
      else $error("full word fold did not finish in eight cycles");

   // A new result only appears out of the final state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == fnvh64_pkg::ST_FOLD))
      else $error("result raised outside the final state");

endmodule

`default_nettype wire
